>>> design/rgdm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgdm_pkg: shared types and constants of the deadlock manager
// Item layouts, command and register codes, store operations, state machine
// encodings and the status bundle of the cycle detector.
// ----------------------------------------------------------------------------
package rgdm_pkg;

  // field widths fixed by the item layout
  localparam int CMD_W     = 3;
  localparam int IDX_W     = 4;
  localparam int CNT_W     = 5;
  localparam int CFG_IDX_W = 1;

  // command codes
  localparam logic [CMD_W-1:0] CMD_REQUEST  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOCATE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DETECT   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RECOVER  = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESOURCE_COUNT = 1'b1;

  // count registers after reset
  localparam logic [CNT_W-1:0] COUNT_RESET = 5'd16;

  // input item
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] process;
    logic [IDX_W-1:0] resource;
  } in_item_t;

  // result item
  typedef struct packed {
    logic deadlock;
    logic changed;
  } out_item_t;

  // matrix store operations
  typedef enum logic [1:0] {
    ST_NONE,
    ST_SET_REQ,
    ST_ALLOC,
    ST_RELEASE
  } st_op_e;

  // command sequencer states
  typedef enum logic [2:0] {
    CTL_IDLE,
    CTL_DETECT,
    CTL_SCAN,
    CTL_REC_DET,
    CTL_FINAL_DET,
    CTL_RESP
  } ctl_state_e;

  // cycle detector states
  typedef enum logic [1:0] {
    DET_IDLE,
    DET_GATHER,
    DET_PEEL
  } det_state_e;

  // cycle detector status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
    logic dead;
  } det_status_t;

endpackage

>>> design/resource_graph_deadlock_manager_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resource_graph_deadlock_manager_core: wait-for graph deadlock manager
// Keeps request and allocation matrices for single-instance resources and
// runs request, allocate, release, detect and recover commands.
//
//   channel  direction  handshake                 payload
//   in       to core    in_valid_i / in_stall_o    in_item_i (cmd, process, resource)
//   out      from core  out_valid_o / out_stall_i  out_item_o (deadlock, changed)
//   cfg      to core    cfg_we_i                   cfg_idx_i, cfg_data_i
//
// Request, allocate, release and unknown codes: the result goes from the response
// state into the output register. Detect: a gather pass over the processes in use,
// then the peeling loop, one process per cycle, until a pass removes nothing.
// Recover: a scan of the cells in use plus one detect after each release.
// A new item is taken while the previous result waits in the output register.
// Reset clears the matrices and free flags at once; no clearing pass.
// ----------------------------------------------------------------------------
module resource_graph_deadlock_manager_core
  import rgdm_pkg::*;
#(
  parameter int MAX_PROCESSES = 16,
  parameter int MAX_RESOURCES = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CNT_W-1:0]     cfg_data_i
);

  localparam int PW  = $clog2(MAX_PROCESSES);
  localparam int RW  = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int PCW = $clog2(MAX_PROCESSES + 1);
  localparam int RCW = $clog2(MAX_RESOURCES + 1);

  ctl_state_e      state_q, state_d;
  logic [CNT_W-1:0] proc_cnt_q, res_cnt_q;
  logic [PCW-1:0]   pcur_q, pcur_d;
  logic [RCW-1:0]   rcur_q, rcur_d;
  logic             scan_end_q, scan_end_d;
  logic             dead_q, dead_d;
  logic             changed_q, changed_d;
  logic             out_valid_q;
  out_item_t        out_q;

  logic [PCW-1:0]           pc_eff;
  logic [RCW-1:0]           rc_eff;
  logic [PW-1:0]            row_sel;
  logic [RW-1:0]            col_sel;
  st_op_e                   st_op;
  logic [MAX_RESOURCES-1:0] req_row, alloc_row, free_row;
  logic [PW-1:0]            det_row;
  det_status_t              det_status;
  logic                     det_start;
  logic                     in_accept;
  logic                     in_range;
  logic                     p_last, r_last;
  logic                     resp_load;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proc_cnt_q <= COUNT_RESET;
      res_cnt_q  <= COUNT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PROCESS_COUNT:  proc_cnt_q <= cfg_data_i;
        CFG_RESOURCE_COUNT: res_cnt_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // counts saturated to the array sizes
  assign pc_eff = (int'(proc_cnt_q) > MAX_PROCESSES) ? PCW'(MAX_PROCESSES) : PCW'(proc_cnt_q);
  assign rc_eff = (int'(res_cnt_q) > MAX_RESOURCES) ? RCW'(MAX_RESOURCES) : RCW'(res_cnt_q);

  assign in_stall_o = (state_q != CTL_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_range   = (int'(in_item_i.process) < int'(pc_eff))
                   && (int'(in_item_i.resource) < int'(rc_eff));
  assign p_last     = (pcur_q == pc_eff - PCW'(1));
  assign r_last     = (rcur_q == rc_eff - RCW'(1));
  assign resp_load  = (state_q == CTL_RESP) && (!out_valid_q || !out_stall_i);

  // matrix store
  rgdm_store #(
    .MAX_PROCESSES(MAX_PROCESSES),
    .MAX_RESOURCES(MAX_RESOURCES)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .row_i      (row_sel),
    .col_i      (col_sel),
    .op_i       (st_op),
    .req_row_o  (req_row),
    .alloc_row_o(alloc_row),
    .free_o     (free_row)
  );

  // cycle detector
  rgdm_detect #(
    .MAX_PROCESSES(MAX_PROCESSES),
    .MAX_RESOURCES(MAX_RESOURCES)
  ) u_detect (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (det_start),
    .pc_eff_i   (pc_eff),
    .rc_eff_i   (rc_eff),
    .req_row_i  (req_row),
    .alloc_row_i(alloc_row),
    .row_o      (det_row),
    .status_o   (det_status)
  );

  // command sequencer
  always_comb begin
    state_d    = state_q;
    pcur_d     = pcur_q;
    rcur_d     = rcur_q;
    scan_end_d = scan_end_q;
    dead_d     = dead_q;
    changed_d  = changed_q;
    row_sel    = det_row;
    col_sel    = rcur_q[RW-1:0];
    st_op      = ST_NONE;
    det_start  = 1'b0;
    case (state_q)
      CTL_IDLE: begin
        row_sel = PW'(in_item_i.process);
        col_sel = RW'(in_item_i.resource);
        if (in_accept) begin
          dead_d    = 1'b0;
          changed_d = 1'b0;
          state_d   = CTL_RESP;
          case (in_item_i.cmd)
            CMD_REQUEST: begin
              if (in_range && !req_row[col_sel]) begin
                st_op     = ST_SET_REQ;
                changed_d = 1'b1;
              end
            end
            CMD_ALLOCATE: begin
              if (in_range && free_row[col_sel] && req_row[col_sel]) begin
                st_op     = ST_ALLOC;
                changed_d = 1'b1;
              end
            end
            CMD_RELEASE: begin
              if (in_range && alloc_row[col_sel]) begin
                st_op     = ST_RELEASE;
                changed_d = 1'b1;
              end
            end
            CMD_DETECT: begin
              det_start = 1'b1;
              state_d   = CTL_DETECT;
            end
            CMD_RECOVER: begin
              pcur_d     = '0;
              rcur_d     = '0;
              scan_end_d = 1'b0;
              if (pc_eff == '0 || rc_eff == '0) begin
                det_start = 1'b1;
                state_d   = CTL_FINAL_DET;
              end else begin
                state_d = CTL_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      CTL_DETECT: begin
        if (det_status.done) begin
          dead_d  = det_status.dead;
          state_d = CTL_RESP;
        end
      end
      CTL_SCAN: begin
        // one cell per cycle while no detect runs, process-major then resource
        row_sel    = pcur_q[PW-1:0];
        scan_end_d = p_last && r_last;
        if (r_last) begin
          rcur_d = '0;
          pcur_d = pcur_q + PCW'(1);
        end else begin
          rcur_d = rcur_q + RCW'(1);
        end
        if (alloc_row[col_sel]) begin
          st_op     = ST_RELEASE;
          changed_d = 1'b1;
          det_start = 1'b1;
          state_d   = CTL_REC_DET;
        end else if (p_last && r_last) begin
          det_start = 1'b1;
          state_d   = CTL_FINAL_DET;
        end
      end
      CTL_REC_DET: begin
        if (det_status.done) begin
          if (!det_status.dead) begin
            dead_d  = 1'b0;
            state_d = CTL_RESP;
          end else if (scan_end_q) begin
            dead_d  = 1'b1;
            state_d = CTL_RESP;
          end else begin
            state_d = CTL_SCAN;
          end
        end
      end
      CTL_FINAL_DET: begin
        if (det_status.done) begin
          dead_d  = det_status.dead;
          state_d = CTL_RESP;
        end
      end
      CTL_RESP: begin
        if (resp_load) begin
          state_d = CTL_IDLE;
        end
      end
      default: begin
        state_d = CTL_IDLE;
      end
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= CTL_IDLE;
      pcur_q     <= '0;
      rcur_q     <= '0;
      scan_end_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      pcur_q     <= pcur_d;
      rcur_q     <= rcur_d;
      scan_end_q <= scan_end_d;
    end
  end

  // pending result bits
  always_ff @(posedge clk_i) begin
    dead_q    <= dead_d;
    changed_q <= changed_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (resp_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (resp_load) begin
      out_q <= '{deadlock: dead_q, changed: changed_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // detector is only started while at rest
  a_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    det_start |-> !det_status.busy)
    else $error("detector started while busy");

  // detector completion lands only where the sequencer waits for it
  a_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    det_status.done |-> (state_q == CTL_DETECT || state_q == CTL_REC_DET
                         || state_q == CTL_FINAL_DET))
    else $error("detector finished with nobody waiting");

  // matrices change only on an accepted item or during the recover scan
  a_store_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_op != ST_NONE) |-> (state_q == CTL_SCAN || in_accept))
    else $error("store written outside a command");

  // a held-back result keeps the sequencer from taking new items
  a_resp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CTL_RESP && out_valid_q && out_stall_i) |=> state_q == CTL_RESP)
    else $error("result dropped while output stalled");

endmodule

>>> design/rgdm_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgdm_store: request and allocation matrices with resource free flags
// One row of resource bits per process in each matrix, read at one shared
// row address, updated by one operation per cycle.
// ----------------------------------------------------------------------------
module rgdm_store
  import rgdm_pkg::*;
#(
  parameter int MAX_PROCESSES = 16,
  parameter int MAX_RESOURCES = 16,
  localparam int PW = $clog2(MAX_PROCESSES),
  localparam int RW = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [PW-1:0]            row_i,
  input  logic [RW-1:0]            col_i,
  input  st_op_e                   op_i,
  output logic [MAX_RESOURCES-1:0] req_row_o,
  output logic [MAX_RESOURCES-1:0] alloc_row_o,
  output logic [MAX_RESOURCES-1:0] free_o
);

  logic [MAX_RESOURCES-1:0] req_q   [MAX_PROCESSES];
  logic [MAX_RESOURCES-1:0] alloc_q [MAX_PROCESSES];
  logic [MAX_RESOURCES-1:0] free_q;

  // row read at the shared address
  assign req_row_o   = req_q[row_i];
  assign alloc_row_o = alloc_q[row_i];
  assign free_o      = free_q;

  // single bit updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_PROCESSES; k++) begin
        req_q[k]   <= '0;
        alloc_q[k] <= '0;
      end
      free_q <= '1;
    end else begin
      case (op_i)
        ST_SET_REQ: begin
          req_q[row_i][col_i] <= 1'b1;
        end
        ST_ALLOC: begin
          alloc_q[row_i][col_i] <= 1'b1;
          req_q[row_i][col_i]   <= 1'b0;
          free_q[col_i]         <= 1'b0;
        end
        ST_RELEASE: begin
          alloc_q[row_i][col_i] <= 1'b0;
          free_q[col_i]         <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> design/rgdm_detect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgdm_detect: iterative wait-for cycle detector
// Gathers the resources held by live processes, then peels processes whose
// requests meet no live holder, one process per cycle through one shared
// row test, until a whole pass removes nothing. Survivors mean a cycle.
// ----------------------------------------------------------------------------
module rgdm_detect
  import rgdm_pkg::*;
#(
  parameter int MAX_PROCESSES = 16,
  parameter int MAX_RESOURCES = 16,
  localparam int PW  = $clog2(MAX_PROCESSES),
  localparam int PCW = $clog2(MAX_PROCESSES + 1),
  localparam int RCW = $clog2(MAX_RESOURCES + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [PCW-1:0]           pc_eff_i,
  input  logic [RCW-1:0]           rc_eff_i,
  input  logic [MAX_RESOURCES-1:0] req_row_i,
  input  logic [MAX_RESOURCES-1:0] alloc_row_i,
  output logic [PW-1:0]            row_o,
  output det_status_t              status_o
);

  det_state_e               state_q, state_d;
  logic [PCW-1:0]           cur_q, cur_d;
  logic [MAX_RESOURCES-1:0] held_q, held_d;
  logic [MAX_PROCESSES-1:0] alive_q, alive_d;
  logic                     progress_q, progress_d;
  logic                     dead_q, dead_d;
  logic                     done_q, done_d;

  logic [MAX_PROCESSES-1:0] proc_mask;
  logic [MAX_RESOURCES-1:0] res_mask;
  logic [PW-1:0]            cur_idx;
  logic                     cur_last;
  logic                     blocked;
  logic                     removed;

  // masks of the processes and resources in use
  always_comb begin
    for (int k = 0; k < MAX_PROCESSES; k++) begin
      proc_mask[k] = (k < int'(pc_eff_i));
    end
    for (int k = 0; k < MAX_RESOURCES; k++) begin
      res_mask[k] = (k < int'(rc_eff_i));
    end
  end

  assign cur_idx  = cur_q[PW-1:0];
  assign cur_last = (cur_q == pc_eff_i - PCW'(1));
  assign row_o    = cur_idx;

  // shared row test: does this process want a resource a live process holds
  assign blocked = |(req_row_i & res_mask & held_q);
  assign removed = (state_q == DET_PEEL) && alive_q[cur_idx] && !blocked;

  // next state and datapath
  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    held_d     = held_q;
    alive_d    = alive_q;
    progress_d = progress_q;
    dead_d     = dead_q;
    done_d     = 1'b0;
    case (state_q)
      DET_IDLE: begin
        if (start_i) begin
          cur_d      = '0;
          held_d     = '0;
          alive_d    = proc_mask;
          progress_d = 1'b0;
          if (pc_eff_i == '0) begin
            dead_d = 1'b0;
            done_d = 1'b1;
          end else begin
            state_d = DET_GATHER;
          end
        end
      end
      DET_GATHER: begin
        held_d = held_q | alloc_row_i;
        if (cur_last) begin
          cur_d   = '0;
          state_d = DET_PEEL;
        end else begin
          cur_d = cur_q + PCW'(1);
        end
      end
      DET_PEEL: begin
        if (removed) begin
          alive_d[cur_idx] = 1'b0;
          held_d           = held_q & ~alloc_row_i;
          progress_d       = 1'b1;
        end
        if (cur_last) begin
          cur_d      = '0;
          progress_d = 1'b0;
          // a pass without removals is the fixed point
          if (!(progress_q || removed)) begin
            dead_d  = |alive_d;
            done_d  = 1'b1;
            state_d = DET_IDLE;
          end
        end else begin
          cur_d = cur_q + PCW'(1);
        end
      end
      default: begin
        state_d = DET_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= DET_IDLE;
      cur_q      <= '0;
      progress_q <= 1'b0;
      done_q     <= 1'b0;
      dead_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      cur_q      <= cur_d;
      progress_q <= progress_d;
      done_q     <= done_d;
      dead_q     <= dead_d;
    end
  end

  // working sets
  always_ff @(posedge clk_i) begin
    held_q  <= held_d;
    alive_q <= alive_d;
  end

  assign status_o = '{busy: (state_q != DET_IDLE), done: done_q, dead: dead_q};

  // a start only arrives while the detector rests
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == DET_IDLE)
    else $error("detect started while busy");

  // completion is a single cycle pulse
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("detect done held longer than one cycle");

  // peeling never revives a process
  a_alive_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == DET_PEEL && state_d == DET_PEEL) |=> ((alive_q & ~$past(alive_q)) == '0))
    else $error("process revived during peeling");

endmodule

>>> bench/rgdm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgdm_checker: result checker for the deadlock manager
// Watches the command, result and register channels of the core. It keeps
// its own copy of the request and allocation matrices, the free flags and the
// count registers, works out the result of every accepted command, and
// compares each accepted result with the oldest one still awaited.
// ----------------------------------------------------------------------------
module rgdm_checker
  import rgdm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  in_item_t             in_item_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  out_item_t            out_item_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CNT_W-1:0]     cfg_data_i,
  output int                   mismatch_count_o,
  output int                   pending_o,
  output int                   checked_o,
  output int                   deadlocks_o
);

  localparam int NPROC = 16;
  localparam int NRES  = 16;

  // an awaited result together with the command that caused it
  typedef struct packed {
    in_item_t  cause;
    out_item_t want;
  } awaited_t;

  awaited_t         awaited_results [$];
  logic [NRES-1:0]  request_map [NPROC];
  logic [NRES-1:0]  held_map [NPROC];
  logic [NRES-1:0]  free_map;
  logic [CNT_W-1:0] proc_raw;
  logic [CNT_W-1:0] res_raw;

  // register value as the number of rows or columns actually in use
  function automatic int clamp_count(input logic [CNT_W-1:0] raw);
    return (raw > NPROC) ? NPROC : int'(raw);
  endfunction

  function automatic logic [NRES-1:0] low_bits(input int n);
    return (n >= NRES) ? '1 : NRES'((32'd1 << n) - 1);
  endfunction

  // peel off processes that wait on nobody still alive; survivors form a cycle
  function automatic bit graph_has_cycle();
    int              pc;
    int              rc;
    logic [NRES-1:0] rmask;
    logic [NPROC-1:0] alive;
    logic [NPROC-1:0] waits_on [NPROC];
    bit              progress;
    pc = clamp_count(proc_raw);
    rc = clamp_count(res_raw);
    rmask = low_bits(rc);
    alive = low_bits(pc);
    for (int p = 0; p < NPROC; p++) begin
      waits_on[p] = '0;
      if (p < pc) begin
        for (int i = 0; i < pc; i++) begin
          if ((request_map[p] & rmask & held_map[i]) != '0) waits_on[p][i] = 1'b1;
        end
      end
    end
    progress = 1'b1;
    while (progress) begin
      progress = 1'b0;
      for (int p = 0; p < pc; p++) begin
        if (alive[p] && (waits_on[p] & alive) == '0) begin
          alive[p] = 1'b0;
          progress = 1'b1;
        end
      end
    end
    return alive != '0;
  endfunction

  // update the matrices for one command and return its result
  function automatic out_item_t apply_command(input in_item_t it);
    out_item_t res;
    int        pc;
    int        rc;
    bit        fits;
    bit        settled;
    res = '0;
    pc = clamp_count(proc_raw);
    rc = clamp_count(res_raw);
    fits = (int'(it.process) < pc) && (int'(it.resource) < rc);
    case (it.cmd)
      CMD_REQUEST: begin
        if (fits && !request_map[it.process][it.resource]) begin
          request_map[it.process][it.resource] = 1'b1;
          res.changed = 1'b1;
        end
      end
      CMD_ALLOCATE: begin
        if (fits && free_map[it.resource] && request_map[it.process][it.resource]) begin
          held_map[it.process][it.resource] = 1'b1;
          request_map[it.process][it.resource] = 1'b0;
          free_map[it.resource] = 1'b0;
          res.changed = 1'b1;
        end
      end
      CMD_RELEASE: begin
        if (fits && held_map[it.process][it.resource]) begin
          held_map[it.process][it.resource] = 1'b0;
          free_map[it.resource] = 1'b1;
          res.changed = 1'b1;
        end
      end
      CMD_DETECT: begin
        res.deadlock = graph_has_cycle();
      end
      CMD_RECOVER: begin
        // release held pairs process-major until the cycle is gone
        settled = 1'b0;
        for (int i = 0; i < pc && !settled; i++) begin
          for (int j = 0; j < rc && !settled; j++) begin
            if (held_map[i][j]) begin
              held_map[i][j] = 1'b0;
              free_map[j] = 1'b1;
              res.changed = 1'b1;
              if (!graph_has_cycle()) settled = 1'b1;
            end
          end
        end
        res.deadlock = graph_has_cycle();
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // channel monitor: results are checked before the new command is queued
  always @(posedge clk_i or negedge rst_ni) begin
    awaited_t head;
    if (!rst_ni) begin
      for (int p = 0; p < NPROC; p++) begin
        request_map[p] = '0;
        held_map[p] = '0;
      end
      free_map = '1;
      proc_raw = COUNT_RESET;
      res_raw = COUNT_RESET;
      awaited_results.delete();
      mismatch_count_o = 0;
      pending_o = 0;
      checked_o = 0;
      deadlocks_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_PROCESS_COUNT) proc_raw = cfg_data_i;
        else if (cfg_idx_i == CFG_RESOURCE_COUNT) res_raw = cfg_data_i;
      end
      if (out_valid_i && !out_stall_i) begin
        checked_o++;
        if (out_item_i.deadlock === 1'b1) deadlocks_o++;
        if (awaited_results.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10)
            $display("checker: result deadlock=%b changed=%b arrived with none awaited",
                     out_item_i.deadlock, out_item_i.changed);
        end else begin
          head = awaited_results.pop_front();
          if (out_item_i.deadlock !== head.want.deadlock ||
              out_item_i.changed !== head.want.changed) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10)
              $display({"checker: cmd %0d p=%0d r=%0d: expected deadlock=%b changed=%b,",
                        " got deadlock=%b changed=%b"},
                       head.cause.cmd, head.cause.process, head.cause.resource,
                       head.want.deadlock, head.want.changed,
                       out_item_i.deadlock, out_item_i.changed);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        head.cause = in_item_i;
        head.want = apply_command(in_item_i);
        awaited_results.push_back(head);
      end
      pending_o = awaited_results.size();
    end
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the wait-for graph deadlock manager
// A directed opening walks through empty detect and recover, repeated and
// failed commands, a self-loop, a two-process cycle, unused command codes and
// zero and oversized counts. Random phases then run under several count
// settings, mixing request/allocate pairs and deliberate cycles with random
// commands, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top
  import rgdm_pkg::*;
;

  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 144;
  localparam int HOLD_CYCLES = 300;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  in_item_t             in_item_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  out_item_t            out_item_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CNT_W-1:0]     cfg_data_i;

  int   mismatches;
  int   pending;
  int   checked;
  int   deadlocks;
  int   items_sent;
  int   cmd_tally [8];
  int   proc_eff;
  int   res_eff;
  logic calm;
  logic hold_go;

  resource_graph_deadlock_manager_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  rgdm_checker result_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .in_item_i       (in_item_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_item_i      (out_item_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .mismatch_count_o(mismatches),
    .pending_o       (pending),
    .checked_o       (checked),
    .deadlocks_o     (deadlocks)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #30_000_000;
    $display("tb_top: timeout with %0d results outstanding", pending);
    $display("tb_top: FAIL");
    $finish;
  end

  // result side: random stalls, one long hold-off, calm during the quiet phase
  initial begin : result_sink
    int hold_left;
    bit hold_taken;
    hold_left = 0;
    hold_taken = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (calm) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < 30);
      end
    end
  end

  function automatic in_item_t item_of(input logic [CMD_W-1:0] c, input int p, input int r);
    in_item_t it;
    it.cmd = c;
    it.process = IDX_W'(p);
    it.resource = IDX_W'(r);
    return it;
  endfunction

  // mostly an index in use, now and then any index
  function automatic int draw_index(input int cnt);
    if (cnt == 0 || $urandom_range(99) < 8) return $urandom_range(15);
    return $urandom_range(cnt - 1);
  endfunction

  function automatic int in_use(input logic [CNT_W-1:0] raw);
    return (raw > 16) ? 16 : int'(raw);
  endfunction

  // offer one item after a random idle gap and wait for its acceptance
  task automatic offer(input in_item_t it);
    int gap;
    gap = 0;
    while (!calm && $urandom_range(99) < 30) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    cmd_tally[it.cmd]++;
  endtask

  // stop offering until every awaited result has come back
  task automatic wait_drained(input int settle);
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic program_counts(input logic [CNT_W-1:0] procs, input logic [CNT_W-1:0] ress);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_PROCESS_COUNT;
    cfg_data_i <= procs;
    @(posedge clk_i);
    cfg_idx_i <= CFG_RESOURCE_COUNT;
    cfg_data_i <= ress;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    proc_eff = in_use(procs);
    res_eff = in_use(ress);
  endtask

  initial begin : stimulus
    int               sel;
    int               pa;
    int               pb;
    int               ra;
    int               rb;
    int               phase_items;
    logic [CNT_W-1:0] procs;
    logic [CNT_W-1:0] ress;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_PROCESS_COUNT;
    cfg_data_i = '0;
    calm = 1'b0;
    hold_go = 1'b0;
    items_sent = 0;
    proc_eff = in_use(COUNT_RESET);
    res_eff = in_use(COUNT_RESET);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty matrices, repeated request, failed allocate and release, self-loop
    offer(item_of(CMD_DETECT, 0, 0));
    offer(item_of(CMD_RECOVER, 0, 0));
    offer(item_of(CMD_REQUEST, 15, 15));
    offer(item_of(CMD_REQUEST, 15, 15));
    offer(item_of(CMD_ALLOCATE, 15, 15));
    offer(item_of(CMD_ALLOCATE, 0, 0));
    offer(item_of(CMD_REQUEST, 15, 15));
    offer(item_of(CMD_DETECT, 0, 0));
    offer(item_of(CMD_RELEASE, 0, 0));
    offer(item_of(CMD_RECOVER, 0, 0));
    // two processes each holding what the other wants
    offer(item_of(CMD_REQUEST, 0, 1));
    offer(item_of(CMD_ALLOCATE, 0, 1));
    offer(item_of(CMD_REQUEST, 1, 2));
    offer(item_of(CMD_ALLOCATE, 1, 2));
    offer(item_of(CMD_REQUEST, 0, 2));
    offer(item_of(CMD_REQUEST, 1, 1));
    offer(item_of(CMD_DETECT, 0, 0));
    // unused command codes
    offer(item_of(CMD_W'(CMD_RECOVER + 1), 15, 0));
    offer(item_of({CMD_W{1'b1}}, 0, 15));
    offer(item_of(CMD_RELEASE, 1, 2));
    offer(item_of(CMD_DETECT, 0, 0));
    offer(item_of(CMD_RECOVER, 0, 0));
    wait_drained(4);
    // no processes in use, oversized resource count
    program_counts(CNT_W'(0), CNT_W'(31));
    offer(item_of(CMD_REQUEST, 3, 3));
    offer(item_of(CMD_DETECT, 0, 0));
    wait_drained(4);

    // random phases under varying counts
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin procs = CNT_W'(16); ress = CNT_W'(16); end
        1: begin procs = CNT_W'(4);  ress = CNT_W'(4);  end
        2: begin procs = CNT_W'(2);  ress = CNT_W'(2);  end
        3: begin procs = CNT_W'(1);  ress = CNT_W'(1);  end
        4: begin procs = CNT_W'(3);  ress = CNT_W'(8);  end
        5: begin procs = CNT_W'(31); ress = CNT_W'(31); end
        6: begin procs = CNT_W'(16); ress = CNT_W'(1);  end
        default: begin procs = CNT_W'(8); ress = CNT_W'(16); end
      endcase
      program_counts(procs, ress);
      calm <= (ph == 2);
      if (ph == 1) hold_go <= 1'b1;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        sel = $urandom_range(99);
        if (sel < 40) begin
          // request followed by allocate of the same pair
          pa = draw_index(proc_eff);
          ra = draw_index(res_eff);
          offer(item_of(CMD_REQUEST, pa, ra));
          offer(item_of(CMD_ALLOCATE, pa, ra));
          phase_items += 2;
        end else if (sel < 50) begin
          if (proc_eff >= 2 && res_eff >= 2) begin
            // crossed holds and requests between two processes
            pa = $urandom_range(proc_eff - 1);
            pb = (pa + 1 + $urandom_range(proc_eff - 2)) % proc_eff;
            ra = $urandom_range(res_eff - 1);
            rb = (ra + 1 + $urandom_range(res_eff - 2)) % res_eff;
            offer(item_of(CMD_REQUEST, pa, ra));
            offer(item_of(CMD_ALLOCATE, pa, ra));
            offer(item_of(CMD_REQUEST, pb, rb));
            offer(item_of(CMD_ALLOCATE, pb, rb));
            offer(item_of(CMD_REQUEST, pa, rb));
            offer(item_of(CMD_REQUEST, pb, ra));
            offer(item_of(CMD_DETECT, pa, rb));
            phase_items += 7;
          end else begin
            // a process asking again for what it holds
            pa = draw_index(proc_eff);
            ra = draw_index(res_eff);
            offer(item_of(CMD_REQUEST, pa, ra));
            offer(item_of(CMD_ALLOCATE, pa, ra));
            offer(item_of(CMD_REQUEST, pa, ra));
            offer(item_of(CMD_DETECT, pa, ra));
            phase_items += 4;
          end
        end else begin
          // one random command
          sel = $urandom_range(99);
          pa = draw_index(proc_eff);
          ra = draw_index(res_eff);
          if (sel < 34) offer(item_of(CMD_REQUEST, pa, ra));
          else if (sel < 60) offer(item_of(CMD_ALLOCATE, pa, ra));
          else if (sel < 75) offer(item_of(CMD_RELEASE, pa, ra));
          else if (sel < 92) offer(item_of(CMD_DETECT, pa, ra));
          else if (sel < 96) offer(item_of(CMD_RECOVER, pa, ra));
          else offer(item_of(CMD_W'($urandom_range((1 << CMD_W) - 1, int'(CMD_RECOVER) + 1)),
                             pa, ra));
          phase_items++;
        end
      end
      wait_drained(4);
    end

    // watch for stray results before the verdict
    wait_drained(HOLD_CYCLES);
    $display("tb_top: %0d items over %0d count settings: %0d detect, %0d recover, %0d unused",
             items_sent, PHASES + 2, cmd_tally[CMD_DETECT], cmd_tally[CMD_RECOVER],
             cmd_tally[CMD_RECOVER + 1] + cmd_tally[CMD_RECOVER + 2] + cmd_tally[CMD_RECOVER + 3]);
    $display("tb_top: %0d results checked, %0d with deadlock set, %0d mismatches",
             checked, deadlocks, mismatches);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/rgdm_pkg.sv
design/rgdm_store.sv
design/rgdm_detect.sv
design/resource_graph_deadlock_manager_core.sv
bench/rgdm_checker.sv
bench/tb_top.sv
